// File: hw/rtl/ngsp_pkg.sv
// ----------------------------------------------------------------------------
// ngsp_pkg
// Shared types, constants and helpers for the NMEA GSA/GGA sentence parser.
// ----------------------------------------------------------------------------
package ngsp_pkg;

	localparam int MAX_LINE_BYTES     = 128;
	localparam int MINUTE_FRAC_DIGITS = 4;
	localparam int FRAC_KEEP = (MINUTE_FRAC_DIGITS < 1) ? 1 :
		((MINUTE_FRAC_DIGITS > 5) ? 5 : MINUTE_FRAC_DIGITS);

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_POINT  = 8'h2E;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_S      = 8'h53;
	localparam logic [7:0] CH_W      = 8'h57;

	localparam logic [39:0] NAME_GSA = 40'h4750475341;
	localparam logic [39:0] NAME_GGA = 40'h4750474741;
	localparam logic [39:0] NAME_BAD = 40'hFFFFFFFFFF;

	localparam logic [16:0] TIME_MAX    = 17'd86399;
	localparam logic [20:0] ALT_POS_MAX = 21'd999999;
	localparam logic [20:0] ALT_NEG_MAX = 21'd99999;
	localparam logic [20:0] MIN_LIMIT   = (60 * (10 ** FRAC_KEEP) - 1 > 'hFFFFF)
		? 21'hFFFFF : 21'(60 * (10 ** FRAC_KEEP) - 1);

	typedef enum logic [1:0] {
		PH_WAIT = 2'd0,
		PH_BODY = 2'd1,
		PH_HEX  = 2'd2,
		PH_DONE = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		KIND_OTHER = 2'd0,
		KIND_GSA   = 2'd1,
		KIND_GGA   = 2'd2
	} kind_t;

	typedef struct packed {
		logic [1:0]  sentence_kind;
		logic        checksum_ok;
		logic [1:0]  fix_mode;
		logic [16:0] time_of_day_s;
		logic [6:0]  lat_deg;
		logic [19:0] lat_min_e4;
		logic        lat_south;
		logic [7:0]  lon_deg;
		logic [19:0] lon_min_e4;
		logic        lon_west;
		logic [20:0] altitude_dm;
		logic        position_valid;
	} rec_t;

	typedef struct packed {
		logic [7:0]  xor_sum;
		logic [7:0]  rx_check;
		logic [1:0]  hex_count;
		logic [4:0]  field_index;
		logic [3:0]  char_in_field;
		logic [39:0] name_shift;
		logic [2:0]  frac_digits;
		logic        seen_point;
		logic [16:0] time_acc;
		logic [6:0]  lat_deg_acc;
		logic [19:0] lat_min_acc;
		logic [7:0]  lon_deg_acc;
		logic [19:0] lon_min_acc;
		logic [1:0]  hemi;
		logic [20:0] alt_acc;
		logic        alt_negative;
		logic [1:0]  mode_acc;
	} line_t;

	function automatic logic [20:0] pow10(input logic [2:0] e);
		case (e)
			3'd0: pow10 = 21'd1;
			3'd1: pow10 = 21'd10;
			3'd2: pow10 = 21'd100;
			3'd3: pow10 = 21'd1000;
			3'd4: pow10 = 21'd10000;
			3'd5: pow10 = 21'd100000;
			default: pow10 = 21'd0;
		endcase
	endfunction

	function automatic logic [16:0] time_weight(input logic [3:0] p);
		case (p)
			4'd0: time_weight = 17'd36000;
			4'd1: time_weight = 17'd3600;
			4'd2: time_weight = 17'd600;
			4'd3: time_weight = 17'd60;
			4'd4: time_weight = 17'd10;
			4'd5: time_weight = 17'd1;
			default: time_weight = 17'd0;
		endcase
	endfunction

endpackage

// File: hw/rtl/ngsp_field.sv
// ----------------------------------------------------------------------------
// ngsp_field
// Per-byte update of the line state: checksum, hex digits and field decode.
// ----------------------------------------------------------------------------
module ngsp_field (
	input  logic [7:0]           c,
	input  logic [1:0]           phase,
	input  ngsp_pkg::line_t      cur,
	output ngsp_pkg::line_t      nxt,
	output logic [1:0]           nxt_phase
);

	logic        digit;
	logic [3:0]  d;
	logic        first;
	logic [4:0]  hv;
	logic [24:0] mtmp;
	logic [24:0] wide;

	function automatic logic [19:0] min_digit(input logic [19:0] acc, input logic [3:0] dd,
		input logic sp, input logic [2:0] fd);
		logic [27:0] v;
		v = '0;
		if (!sp) begin
			v = 28'(acc) * 28'd10 + 28'(dd) * 28'(ngsp_pkg::pow10(3'(ngsp_pkg::FRAC_KEEP)));
		end else if (fd < 3'(ngsp_pkg::FRAC_KEEP)) begin
			v = 28'(acc) + 28'(dd) * 28'(ngsp_pkg::pow10(3'(ngsp_pkg::FRAC_KEEP) - 3'd1 - fd));
		end else begin
			v = 28'(acc);
		end
		min_digit = (v > 28'(ngsp_pkg::MIN_LIMIT)) ? ngsp_pkg::MIN_LIMIT[19:0] : v[19:0];
	endfunction

	assign digit = (c >= 8'h30) && (c <= 8'h39);
	assign d     = digit ? 4'(c - 8'h30) : 4'd0;
	assign first = (cur.char_in_field == 4'd0) && !cur.seen_point;
	assign mtmp  = '0;
	assign wide  = mtmp;

	always_comb begin
		hv = 5'h1F;
		if (c >= 8'h30 && c <= 8'h39) hv = 5'(c - 8'h30);
		else if (c >= 8'h41 && c <= 8'h46) hv = 5'(c - 8'h41 + 8'd10);
		else if (c >= 8'h61 && c <= 8'h66) hv = 5'(c - 8'h61 + 8'd10);
	end

	always_comb begin
		logic [21:0] t;
		logic [24:0] a;
		logic [11:0] dg;
		nxt       = cur;
		nxt_phase = phase;
		t  = '0;
		a  = wide;
		dg = '0;
		if (phase == ngsp_pkg::PH_BODY) begin
			if (c == ngsp_pkg::CH_STAR) begin
				nxt_phase     = ngsp_pkg::PH_HEX;
				nxt.hex_count = 2'd0;
			end else begin
				nxt.xor_sum = cur.xor_sum ^ c;
				if (c == ngsp_pkg::CH_COMMA) begin
					if (cur.field_index < 5'd31) nxt.field_index = cur.field_index + 5'd1;
					nxt.char_in_field = '0;
					nxt.frac_digits   = '0;
					nxt.seen_point    = 1'b0;
				end else if (cur.field_index == 5'd0) begin
					if (cur.char_in_field < 4'd5) nxt.name_shift = {cur.name_shift[31:0], c};
					else nxt.name_shift = ngsp_pkg::NAME_BAD;
					if (cur.char_in_field < 4'd15) nxt.char_in_field = cur.char_in_field + 4'd1;
				end else if (c == ngsp_pkg::CH_POINT && !cur.seen_point) begin
					if (cur.field_index == 5'd2) nxt.mode_acc = 2'd0;
					nxt.seen_point = 1'b1;
				end else begin
					case (cur.field_index)
						5'd1: begin
							if (digit && !cur.seen_point && cur.char_in_field < 4'd6) begin
								t = 22'(cur.time_acc) + 22'(d) * 22'(ngsp_pkg::time_weight(cur.char_in_field));
								nxt.time_acc = (t > 22'(ngsp_pkg::TIME_MAX)) ? ngsp_pkg::TIME_MAX : t[16:0];
							end
						end
						5'd2: begin
							nxt.mode_acc = (first && c >= 8'h30 && c <= 8'h33) ? 2'(c - 8'h30) : 2'd0;
							if (digit) begin
								if (!cur.seen_point && cur.char_in_field < 4'd2) begin
									dg = 12'(cur.lat_deg_acc) * 12'd10 + 12'(d);
									nxt.lat_deg_acc = (dg > 12'd90) ? 7'd90 : dg[6:0];
								end else begin
									nxt.lat_min_acc = min_digit(cur.lat_min_acc, d, cur.seen_point,
										cur.frac_digits);
								end
							end
						end
						5'd3: if (first && c == ngsp_pkg::CH_S) nxt.hemi[0] = 1'b1;
						5'd4: begin
							if (digit) begin
								if (!cur.seen_point && cur.char_in_field < 4'd3) begin
									dg = 12'(cur.lon_deg_acc) * 12'd10 + 12'(d);
									nxt.lon_deg_acc = (dg > 12'd180) ? 8'd180 : dg[7:0];
								end else begin
									nxt.lon_min_acc = min_digit(cur.lon_min_acc, d, cur.seen_point,
										cur.frac_digits);
								end
							end
						end
						5'd5: if (first && c == ngsp_pkg::CH_W) nxt.hemi[1] = 1'b1;
						5'd9: begin
							if (first && c == ngsp_pkg::CH_MINUS) begin
								nxt.alt_negative = 1'b1;
							end else if (digit && !cur.seen_point) begin
								a = 25'(cur.alt_acc) * 25'd10 + 25'(d) * 25'd10;
								nxt.alt_acc = (a > 25'(ngsp_pkg::ALT_POS_MAX)) ?
									ngsp_pkg::ALT_POS_MAX : a[20:0];
							end else if (digit && cur.frac_digits == 3'd0) begin
								a = 25'(cur.alt_acc) + 25'(d);
								nxt.alt_acc = (a > 25'(ngsp_pkg::ALT_POS_MAX)) ?
									ngsp_pkg::ALT_POS_MAX : a[20:0];
							end
						end
						default: ;
					endcase
					if (!cur.seen_point) begin
						if (cur.char_in_field < 4'd15) nxt.char_in_field = cur.char_in_field + 4'd1;
					end else if (cur.frac_digits < 3'd7) begin
						nxt.frac_digits = cur.frac_digits + 3'd1;
					end
				end
			end
		end else if (phase == ngsp_pkg::PH_HEX) begin
			if (hv[4]) begin
				nxt.hex_count = 2'd3;
				nxt_phase     = ngsp_pkg::PH_DONE;
			end else begin
				nxt.rx_check  = {cur.rx_check[3:0], hv[3:0]};
				nxt.hex_count = cur.hex_count + 2'd1;
				if (cur.hex_count == 2'd1) nxt_phase = ngsp_pkg::PH_DONE;
			end
		end
	end

endmodule

// File: hw/rtl/ngsp_record.sv
// ----------------------------------------------------------------------------
// ngsp_record
// Builds the output record from the line state at end of line.
// ----------------------------------------------------------------------------
module ngsp_record (
	input  ngsp_pkg::line_t cur,
	input  logic [1:0]      last_fix,
	output ngsp_pkg::rec_t  rec,
	output logic [1:0]      new_fix
);

	logic [1:0]  kind;
	logic        ok;
	logic [20:0] m;

	always_comb begin
		kind = ngsp_pkg::KIND_OTHER;
		if (cur.char_in_field == 4'd5 || cur.field_index != 5'd0) begin
			if (cur.name_shift == ngsp_pkg::NAME_GSA) kind = ngsp_pkg::KIND_GSA;
			else if (cur.name_shift == ngsp_pkg::NAME_GGA) kind = ngsp_pkg::KIND_GGA;
		end
		ok      = (cur.hex_count == 2'd2) && (cur.xor_sum == cur.rx_check);
		new_fix = (kind == ngsp_pkg::KIND_GSA && ok) ? cur.mode_acc : last_fix;
		m       = (cur.alt_acc > ngsp_pkg::ALT_NEG_MAX) ? ngsp_pkg::ALT_NEG_MAX : cur.alt_acc;
		rec               = '0;
		rec.sentence_kind = kind;
		rec.checksum_ok   = ok;
		rec.fix_mode      = new_fix;
		if (kind == ngsp_pkg::KIND_GGA) begin
			rec.time_of_day_s  = cur.time_acc;
			rec.lat_deg        = cur.lat_deg_acc;
			rec.lat_min_e4     = cur.lat_min_acc;
			rec.lat_south      = cur.hemi[0];
			rec.lon_deg        = cur.lon_deg_acc;
			rec.lon_min_e4     = cur.lon_min_acc;
			rec.lon_west       = cur.hemi[1];
			rec.altitude_dm    = cur.alt_negative ? (21'd0 - m) : cur.alt_acc;
			rec.position_valid = ok && (new_fix == 2'd3);
		end
	end

endmodule

// File: hw/rtl/nmea_gsa_gga_sentence_parser.sv
// ----------------------------------------------------------------------------
// nmea_gsa_gga_sentence_parser
// Byte-stream NMEA parser emitting one record per GPGSA/GPGGA/other line that ends within MAX_LINE_BYTES.
// ----------------------------------------------------------------------------
// One byte is taken every cycle; the line state updates in the same cycle the
// byte is accepted and a record appears in the output register in the cycle after
// the newline byte. The only thing that stops input is a full output register
// that the sink has not taken; the register is freed in the cycle it is read.
module nmea_gsa_gga_sentence_parser (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // rx_byte
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata    // kind,ok,fix,time,lat_deg,lat_min,lat_s,lon_deg,
	                                // lon_min,lon_w,alt,pos_valid; zero pad
);

	ngsp_pkg::line_t line_q, line_nx, line_zero;
	ngsp_pkg::rec_t  rec, rec_q;
	logic [1:0]      phase_q, phase_nx;
	logic            active_q;
	logic [7:0]      count_q;
	logic [1:0]      fix_q, fix_nx;
	logic            acc;
	logic            rec_load;

	assign line_zero = '0;
	assign s_tready  = !m_tvalid || m_tready;
	assign acc       = s_tvalid && s_tready;
	assign rec_load  = acc && active_q && (s_tdata == ngsp_pkg::CH_NL);

	ngsp_field u_field (
		.c(s_tdata), .phase(phase_q), .cur(line_q), .nxt(line_nx), .nxt_phase(phase_nx)
	);

	ngsp_record u_rec (.cur(line_q), .last_fix(fix_q), .rec(rec), .new_fix(fix_nx));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q   <= '0;
			phase_q  <= ngsp_pkg::PH_WAIT;
			active_q <= 1'b0;
			count_q  <= '0;
			fix_q    <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (rec_load) m_tvalid <= 1'b1;
			else if (m_tready) m_tvalid <= 1'b0;
			if (acc) begin
				if (s_tdata == ngsp_pkg::CH_DOLLAR) begin
					line_q   <= line_zero;
					active_q <= 1'b1;
					phase_q  <= ngsp_pkg::PH_BODY;
					count_q  <= 8'd1;
				end else if (active_q) begin
					if (s_tdata == ngsp_pkg::CH_NL) begin
						fix_q    <= fix_nx;
						line_q   <= line_zero;
						active_q <= 1'b0;
						phase_q  <= ngsp_pkg::PH_WAIT;
					end else if (count_q >= 8'(ngsp_pkg::MAX_LINE_BYTES)) begin
						line_q   <= line_zero;
						active_q <= 1'b0;
						phase_q  <= ngsp_pkg::PH_WAIT;
					end else begin
						count_q <= count_q + 8'd1;
						line_q  <= line_nx;
						phase_q <= phase_nx;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rec_load) rec_q <= rec;
	end

	assign m_tdata = {3'd0, rec_q.position_valid, rec_q.altitude_dm, rec_q.lon_west,
		rec_q.lon_min_e4, rec_q.lon_deg, rec_q.lat_south, rec_q.lat_min_e4, rec_q.lat_deg,
		rec_q.time_of_day_s, rec_q.fix_mode, rec_q.checksum_ok, rec_q.sentence_kind};

endmodule

// File: hw/rtl/ngsp_checker.sv
// ----------------------------------------------------------------------------
// ngsp_checker
// Port-level checks for the NMEA sentence parser.
// ----------------------------------------------------------------------------
module ngsp_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [7:0]   s_tdata,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [103:0] m_tdata
);

	a_ready : assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready) else $error("input stalled with empty output");
	a_hold : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("output not held");
	a_kind : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[1:0] != 2'd3) else $error("bad sentence kind");
	a_pv : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[100] |-> m_tdata[2] && m_tdata[4:3] == 2'd3 && m_tdata[1:0] == 2'd2)
		else $error("position_valid without conditions");
	a_only_nl : assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tdata == 8'h0A))
		else $error("record without newline");

endmodule

bind nmea_gsa_gga_sentence_parser ngsp_checker u_ngsp_checker (.*);

// File: verif/nmea_gsa_gga_sentence_parser_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_gsa_gga_sentence_parser_test
// Sends NMEA lines and noise as a byte stream with random gaps and sink
// stalls, predicts each line record and compares it with the output word.
// ----------------------------------------------------------------------------
module nmea_gsa_gga_sentence_parser_test;

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_tvalid = 0;
	logic         s_tready;
	logic [7:0]   s_tdata = 0;
	logic         m_tvalid;
	logic         m_tready = 0;
	logic [103:0] m_tdata;

	nmea_gsa_gga_sentence_parser i_dut (.*);

	always #1 clk = ~clk;

	// line parser model state
	bit          ln_active;
	int unsigned ph, xsum, rxck, hexn, nbytes, fidx, cif, fdig;
	bit          pt_seen, alt_neg;
	longint unsigned nm;
	int unsigned tacc, latd, latm, lond, lonm, hemi, altv, macc, fix_last;

	bit [103:0] records_due[$];
	int  bytes_sent, records_seen, mismatches;
	int  hold_len;
	bit  no_idle;
	longint cycles;

	function automatic int unsigned clip(longint unsigned v, longint unsigned lim);
		return (v > lim) ? int'(lim) : int'(v);
	endfunction

	function automatic int unsigned p10(int unsigned e);
		int unsigned r;
		r = 1;
		repeat (e) r = r * 10;
		return r;
	endfunction

	function automatic void line_clear();
		xsum = 0; rxck = 0; hexn = 0; nbytes = 0; fidx = 0; cif = 0; fdig = 0;
		pt_seen = 0; nm = 0; tacc = 0; latd = 0; latm = 0; lond = 0; lonm = 0;
		hemi = 0; altv = 0; alt_neg = 0; macc = 0;
	endfunction

	function automatic int unsigned minute_digit(int unsigned acc, int unsigned d);
		if (!pt_seen)
			return clip(longint'(acc) * 10 + longint'(d) * p10(ngsp_pkg::FRAC_KEEP),
				ngsp_pkg::MIN_LIMIT);
		if (fdig < ngsp_pkg::FRAC_KEEP)
			return clip(longint'(acc) + longint'(d) * p10(ngsp_pkg::FRAC_KEEP - 1 - fdig),
				ngsp_pkg::MIN_LIMIT);
		return acc;
	endfunction

	function automatic void field_char(int unsigned c);
		bit first, dig;
		int unsigned d;
		first = (cif == 0) && !pt_seen;
		dig = (c >= "0") && (c <= "9");
		d = dig ? c - "0" : 0;
		if (c == ngsp_pkg::CH_COMMA) begin
			if (fidx < 31) fidx++;
			cif = 0; fdig = 0; pt_seen = 0;
			return;
		end
		if (fidx == 0) begin
			if (cif < 5) nm = ((nm << 8) | c) & ngsp_pkg::NAME_BAD;
			else nm = ngsp_pkg::NAME_BAD;
			if (cif < 15) cif++;
			return;
		end
		if (c == ngsp_pkg::CH_POINT && !pt_seen) begin
			if (fidx == 2) macc = 0;
			pt_seen = 1;
			return;
		end
		case (fidx)
			1: if (dig && !pt_seen && cif < 6)
				tacc = clip(longint'(tacc) + longint'(d) * ngsp_pkg::time_weight(4'(cif)),
					ngsp_pkg::TIME_MAX);
			2: begin
				macc = (first && c >= "0" && c <= "3") ? c - "0" : 0;
				if (dig) begin
					if (!pt_seen && cif < 2) latd = clip(latd * 10 + d, 90);
					else latm = minute_digit(latm, d);
				end
			end
			3: if (first && c == ngsp_pkg::CH_S) hemi |= 1;
			4: if (dig) begin
				if (!pt_seen && cif < 3) lond = clip(lond * 10 + d, 180);
				else lonm = minute_digit(lonm, d);
			end
			5: if (first && c == ngsp_pkg::CH_W) hemi |= 2;
			9: begin
				if (first && c == ngsp_pkg::CH_MINUS) alt_neg = 1;
				else if (dig && !pt_seen)
					altv = clip(longint'(altv) * 10 + d * 10, ngsp_pkg::ALT_POS_MAX);
				else if (dig && fdig == 0)
					altv = clip(longint'(altv) + d, ngsp_pkg::ALT_POS_MAX);
			end
			default: ;
		endcase
		if (!pt_seen) begin
			if (cif < 15) cif++;
		end else if (fdig < 7) fdig++;
	endfunction

	function automatic int hex_of(int unsigned c);
		if (c >= "0" && c <= "9") return c - "0";
		if (c >= "A" && c <= "F") return c - "A" + 10;
		if (c >= "a" && c <= "f") return c - "a" + 10;
		return -1;
	endfunction

	function automatic void predict_byte(int unsigned c);
		int h;
		int unsigned m;
		ngsp_pkg::kind_t k;
		bit ok;
		ngsp_pkg::rec_t r;
		bit [103:0] w;
		if (c == ngsp_pkg::CH_DOLLAR) begin
			line_clear();
			ln_active = 1; ph = ngsp_pkg::PH_BODY; nbytes = 1;
			return;
		end
		if (!ln_active) return;
		if (c != ngsp_pkg::CH_NL) begin
			if (nbytes >= ngsp_pkg::MAX_LINE_BYTES) begin
				line_clear(); ln_active = 0; ph = ngsp_pkg::PH_WAIT;
				return;
			end
			nbytes++;
			if (ph == ngsp_pkg::PH_BODY) begin
				if (c == ngsp_pkg::CH_STAR) begin
					ph = ngsp_pkg::PH_HEX; hexn = 0;
				end else begin
					xsum ^= c; field_char(c);
				end
			end else if (ph == ngsp_pkg::PH_HEX) begin
				h = hex_of(c);
				if (h < 0) begin
					hexn = 3; ph = ngsp_pkg::PH_DONE;
				end else begin
					rxck = ((rxck << 4) | h) & 8'hFF;
					hexn++;
					if (hexn == 2) ph = ngsp_pkg::PH_DONE;
				end
			end
			return;
		end
		k = ngsp_pkg::KIND_OTHER;
		if (cif == 5 || fidx > 0) begin
			if (nm == ngsp_pkg::NAME_GSA) k = ngsp_pkg::KIND_GSA;
			else if (nm == ngsp_pkg::NAME_GGA) k = ngsp_pkg::KIND_GGA;
		end
		ok = (hexn == 2 && xsum == rxck);
		if (k == ngsp_pkg::KIND_GSA && ok) fix_last = macc & 3;
		r = '0;
		r.sentence_kind = k;
		r.checksum_ok = ok;
		r.fix_mode = fix_last[1:0];
		if (k == ngsp_pkg::KIND_GGA) begin
			r.time_of_day_s = tacc[16:0];
			r.lat_deg = latd[6:0];
			r.lat_min_e4 = latm[19:0];
			r.lat_south = hemi[0];
			r.lon_deg = lond[7:0];
			r.lon_min_e4 = lonm[19:0];
			r.lon_west = hemi[1];
			if (alt_neg) begin
				m = (altv > ngsp_pkg::ALT_NEG_MAX) ? ngsp_pkg::ALT_NEG_MAX : altv;
				r.altitude_dm = 21'(32'h200000 - m);
			end else r.altitude_dm = altv[20:0];
			r.position_valid = ok && fix_last == 3;
		end
		w = '0;
		w[1:0] = r.sentence_kind;    w[2] = r.checksum_ok;       w[4:3] = r.fix_mode;
		w[21:5] = r.time_of_day_s;   w[28:22] = r.lat_deg;       w[48:29] = r.lat_min_e4;
		w[49] = r.lat_south;         w[57:50] = r.lon_deg;       w[77:58] = r.lon_min_e4;
		w[78] = r.lon_west;          w[99:79] = r.altitude_dm;   w[100] = r.position_valid;
		records_due.push_back(w);
		line_clear(); ln_active = 0; ph = ngsp_pkg::PH_WAIT;
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		predict_byte(b);
		bytes_sent++;
	endtask

	task automatic send_str(input string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i]);
	endtask

	function automatic string digits(int n);
		string s;
		s = "";
		repeat (n) s = {s, string'(8'("0" + $urandom_range(0, 9)))};
		return s;
	endfunction

	// tail: 0 good upper, 1 good lower, 2 wrong sum, 3 no star, 4 one digit, 5 bad hex
	task automatic send_sentence(input string body, input int tail);
		logic [7:0] x;
		string t;
		string eol;
		x = 0;
		for (int i = 0; i < body.len(); i++) x ^= body[i];
		case (tail)
			0: t = $sformatf("*%02X", x);
			1: t = $sformatf("*%02x", x);
			2: t = $sformatf("*%02X", x ^ 8'(1 << $urandom_range(0, 7)));
			3: t = "";
			4: t = $sformatf("*%1X", x[7:4]);
			default: t = $sformatf("*%1XG", x[7:4]);
		endcase
		if ($urandom_range(0, 1)) eol = "\r\n";
		else eol = "\n";
		send_str({"$", body, t, eol});
	endtask

	function automatic string gga_body();
		string alt;
		string sgn;
		if ($urandom_range(0, 3) == 0) sgn = "-";
		else sgn = "";
		alt = {sgn, digits($urandom_range(0, 7)), ".", digits($urandom_range(0, 2))};
		return $sformatf("GPGGA,%s.%s,%s.%s,%s,%s.%s,%s,%0d,%0d,%0d.%0d,%s,M,,",
			digits($urandom_range(4, 7)), digits($urandom_range(0, 2)),
			digits($urandom_range(2, 5)), digits($urandom_range(0, 6)),
			($urandom_range(0, 1) ? "S" : "N"),
			digits($urandom_range(3, 6)), digits($urandom_range(0, 6)),
			($urandom_range(0, 1) ? "W" : "E"),
			$urandom_range(0, 2), $urandom_range(0, 12), $urandom_range(0, 9),
			$urandom_range(0, 9), alt);
	endfunction

	function automatic string gsa_body();
		string md;
		case ($urandom_range(0, 5))
			0: md = "";
			1: md = "4";
			2: md = "3.";
			default: md = string'(8'("0" + $urandom_range(0, 3)));
		endcase
		return $sformatf("GPGSA,A,%s,%0d,%0d,,,,,,,,,,,1.5,0.9,1.2", md,
			$urandom_range(1, 32), $urandom_range(1, 32));
	endfunction

	task automatic test_directed();
		send_str("\n*x\n");
		send_sentence("GPGSA,A,3,04,05", 0);
		send_sentence("GPGGA,235959,9059.99999,S,18059.99999,W,1,08,0.9,999999.9,M", 0);
		send_sentence("GPGGA,999999.99,9999.9999,N,99999.9999,E,1,08,0.9,-99999.9,M", 1);
		send_sentence("GPGGA,000000,0000.0000,N,00000.0000,E,0,00,0.0,-0.0,M", 0);
		send_sentence("GPGGA,12a456,4.5.6,S,1x2.3,W,1,,,9999999.99,M", 0);
		send_sentence("GPGSA,A,0", 0);
		send_sentence("GPGSA,A,1", 2);
		send_sentence("GPGSA,A,2.", 0);
		send_sentence("GPGSA,A,", 0);
		send_sentence("GPGSA,A,3", 3);
		send_sentence("GPGSA,A,3", 4);
		send_sentence("GPGSA,A,3", 5);
		send_sentence("GPGSA,A,3", 0);
		send_sentence("GPGGA,120000,4807.038,N,01131.000,E,1,08,0.9,545.4,M,,,,,,,,,,,,,,,,,,,,,,,,,,,9", 0);
		send_sentence("GPGSAX,A,3", 0);
		send_sentence("GPGS", 0);
		send_sentence("GPGSA", 0);
		send_str("$GPGGA,1234$GPGSA,A,2*32\n");
		send_str({"$GPGGA,", digits(130), "*00\n"});
		send_str({"$GPGSA,", digits(119), "\n"});
		for (int i = 0; i < 8; i++) send_byte(8'(1 << i));
		send_byte(8'hFF);
		send_byte(8'h00);
	endtask

	task automatic test_random_lines();
		int r;
		while (bytes_sent < 1400 || records_seen + records_due.size() < 60) begin
			no_idle = ($urandom_range(0, 7) == 0);
			r = $urandom_range(0, 19);
			if (r < 8) send_sentence(gga_body(), $urandom_range(0, 9) < 7 ? $urandom_range(0, 1)
				: $urandom_range(2, 5));
			else if (r < 14) send_sentence(gsa_body(), $urandom_range(0, 9) < 7 ? 0
				: $urandom_range(1, 5));
			else if (r < 17) begin
				repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
			end else if (r < 18) send_str({"$", digits($urandom_range(0, 12)), "\n"});
			else send_sentence({"GPGGA,", digits($urandom_range(0, 20))}, $urandom_range(0, 5));
		end
		no_idle = 0;
	endtask

	task automatic test_sink_stall();
		hold_len = 400;
		no_idle = 1;
		repeat (6) send_sentence("GPGSA,A,3", 0);
		no_idle = 0;
	endtask

	initial begin
		while (1) begin
			if (hold_len > 0) begin
				m_tready <= 0;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
			end
			if ($urandom_range(0, 3) != 0) begin
				m_tready <= 0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
			m_tready <= 1;
			do @(posedge clk); while (!m_tvalid && hold_len == 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			records_seen++;
			if (records_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected word %h", m_tdata);
			end else if (records_due[0] !== m_tdata) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected %h actual %h", records_due[0], m_tdata);
				void'(records_due.pop_front());
			end else void'(records_due.pop_front());
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_random_lines();
		test_sink_stall();
		test_random_lines();
		s_tvalid <= 0;
		while (records_due.size() > 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0 && records_due.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
